// ===== sv/midi_stream_parser_macros.svh =====
`ifndef MIDI_STREAM_PARSER_MACROS_SVH
`define MIDI_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("midi_stream_parser: check failed");

// Next-cycle implication.
`define MSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("midi_stream_parser: check failed");

`endif

// ===== sv/msp_pkg.sv =====
package msp_pkg;

  localparam int unsigned SYSEX_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA1,
    PH_DATA2,
    PH_SYSEX
  } phase_e;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_READ,
    ST_LOAD
  } seq_e;

  localparam logic [1:0] KIND_CHAN  = 2'd0;
  localparam logic [1:0] KIND_RT    = 2'd1;
  localparam logic [1:0] KIND_SYSEX = 2'd2;

  localparam logic [7:0] RT_MIN   = 8'hF8;
  localparam logic [7:0] SX_START = 8'hF0;
  localparam logic [7:0] SX_END   = 8'hF7;
  localparam logic [7:0] SC_MIN   = 8'hF1;

  // program change and channel pressure carry one data byte
  function automatic logic one_data(input logic [7:0] st);
    return (st[7:4] == 4'hC) || (st[7:4] == 4'hD);
  endfunction

endpackage

// ===== sv/msp_ram.sv =====
module msp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/midi_stream_parser.sv =====
// channel | direction | handshake                | payload
// in      | in        | in_valid_i / in_stall_o  | in_byte_i
// out     | out       | out_valid_o / out_stall_i| kind, status_nibble, channel, first_data,
//         |           |                          | second_data, raw_value, last
// Real-time, channel and SysEx data bytes are taken whenever in_stall_o is low.
// A SysEx end byte with N stored bytes (0xF0, and 0xF7 if it fit, included) gives N items;
// each item passes ST_READ, the registered read of the SysEx RAM, then ST_LOAD.
// Reset is asynchronous, active low; the SysEx RAM is not cleared.
// The single output register frees in the cycle it is taken, so out_stall_i
// backs up into in_stall_o; no input is taken while a SysEx dump runs.
`include "midi_stream_parser_macros.svh"

module midi_stream_parser #(
  parameter int unsigned SYSEX_DEPTH = msp_pkg::SYSEX_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [3:0] status_nibble_o,
  output logic [3:0] channel_o,
  output logic [6:0] first_data_o,
  output logic [6:0] second_data_o,
  output logic [7:0] raw_value_o,
  output logic       last_o
);

  localparam int unsigned AW = $clog2(SYSEX_DEPTH);
  localparam int unsigned CW = $clog2(SYSEX_DEPTH + 1);

  msp_pkg::seq_e   seq_q, seq_d;
  msp_pkg::phase_e phase_q, phase_d;
  logic [7:0]    run_q, run_d;
  logic [7:0]    hstat_q, hstat_d;
  logic [6:0]    hfirst_q, hfirst_d;
  logic [6:0]    hsecond_q, hsecond_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] kind_q, kind_d;
  logic [3:0] sn_q, sn_d;
  logic [3:0] ch_q, ch_d;
  logic [6:0] d1_q, d1_d;
  logic [6:0] d2_q, d2_d;
  logic [7:0] raw_q, raw_d;
  logic       last_q, last_d;

  logic          in_acc, out_free, sx_end_acc, dump_last, load;
  logic          emit_ch, emit_rt, has_room;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((seq_q == msp_pkg::ST_ACCEPT) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sx_end_acc = in_acc && (in_byte_i == msp_pkg::SX_END) &&
                      (phase_q == msp_pkg::PH_SYSEX);
  assign dump_last  = (CW'(idx_q) + CW'(1)) == cnt_q;
  assign load       = (seq_q == msp_pkg::ST_LOAD) && out_free;
  assign has_room   = cnt_q < CW'(SYSEX_DEPTH);

  msp_ram #(
    .WIDTH (8),
    .DEPTH (SYSEX_DEPTH)
  ) u_sysex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (seq_q == msp_pkg::ST_READ),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // dump sequencer
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      msp_pkg::ST_ACCEPT: if (sx_end_acc) seq_d = msp_pkg::ST_READ;
      msp_pkg::ST_READ:   seq_d = msp_pkg::ST_LOAD;
      msp_pkg::ST_LOAD: begin
        if (load) seq_d = dump_last ? msp_pkg::ST_ACCEPT : msp_pkg::ST_READ;
      end
      default:            seq_d = msp_pkg::ST_ACCEPT;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (sx_end_acc) begin
      idx_d = '0;
    end else if (load && !dump_last) begin
      idx_d = idx_q + AW'(1);
    end
  end

  // byte parser
  always_comb begin
    phase_d   = phase_q;
    run_d     = run_q;
    hstat_d   = hstat_q;
    hfirst_d  = hfirst_q;
    hsecond_d = hsecond_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = in_byte_i;
    emit_ch   = 1'b0;
    emit_rt   = 1'b0;
    if (in_acc) begin
      if (in_byte_i >= msp_pkg::RT_MIN) begin
        emit_rt = 1'b1;
      end else if (in_byte_i[7]) begin
        if (in_byte_i == msp_pkg::SX_START) begin
          phase_d   = msp_pkg::PH_SYSEX;
          ram_we    = 1'b1;
          ram_waddr = '0;
          cnt_d     = CW'(1);
        end else if (in_byte_i == msp_pkg::SX_END) begin
          if ((phase_q == msp_pkg::PH_SYSEX) && has_room) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
          phase_d = msp_pkg::PH_IDLE;
        end else if (in_byte_i >= msp_pkg::SC_MIN) begin
          run_d   = '0;
          phase_d = msp_pkg::PH_IDLE;
        end else begin
          hstat_d = in_byte_i;
          run_d   = in_byte_i;
          phase_d = msp_pkg::PH_DATA1;
        end
      end else begin
        case (phase_q)
          msp_pkg::PH_SYSEX: begin
            if (has_room) begin
              ram_we = 1'b1;
              cnt_d  = cnt_q + CW'(1);
            end
          end
          msp_pkg::PH_IDLE: begin
            if (run_q != '0) begin
              hstat_d  = run_q;
              hfirst_d = in_byte_i[6:0];
              if (msp_pkg::one_data(run_q)) begin
                emit_ch = 1'b1;
              end else begin
                phase_d = msp_pkg::PH_DATA2;
              end
            end
          end
          msp_pkg::PH_DATA1: begin
            hfirst_d = in_byte_i[6:0];
            if (msp_pkg::one_data(run_q)) begin
              phase_d = msp_pkg::PH_IDLE;
              emit_ch = 1'b1;
            end else begin
              phase_d = msp_pkg::PH_DATA2;
            end
          end
          msp_pkg::PH_DATA2: begin
            hsecond_d = in_byte_i[6:0];
            phase_d   = msp_pkg::PH_IDLE;
            emit_ch   = 1'b1;
          end
          default: phase_d = msp_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    sn_d        = sn_q;
    ch_d        = ch_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    raw_d       = raw_q;
    last_d      = last_q;
    if (emit_ch) begin
      out_valid_d = 1'b1;
      kind_d      = msp_pkg::KIND_CHAN;
      sn_d        = hstat_d[7:4];
      ch_d        = hstat_d[3:0];
      d1_d        = hfirst_d;
      d2_d        = hsecond_d;
      raw_d       = '0;
      last_d      = 1'b1;
    end else if (emit_rt) begin
      out_valid_d = 1'b1;
      kind_d      = msp_pkg::KIND_RT;
      sn_d        = '0;
      ch_d        = '0;
      d1_d        = '0;
      d2_d        = '0;
      raw_d       = in_byte_i;
      last_d      = 1'b1;
    end else if (load) begin
      out_valid_d = 1'b1;
      kind_d      = msp_pkg::KIND_SYSEX;
      sn_d        = '0;
      ch_d        = '0;
      d1_d        = '0;
      d2_d        = '0;
      raw_d       = ram_rdata;
      last_d      = dump_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= msp_pkg::ST_ACCEPT;
      phase_q     <= msp_pkg::PH_IDLE;
      run_q       <= '0;
      hstat_q     <= '0;
      hfirst_q    <= '0;
      hsecond_q   <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      run_q       <= run_d;
      hstat_q     <= hstat_d;
      hfirst_q    <= hfirst_d;
      hsecond_q   <= hsecond_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    sn_q   <= sn_d;
    ch_q   <= ch_d;
    d1_q   <= d1_d;
    d2_q   <= d2_d;
    raw_q  <= raw_d;
    last_q <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign status_nibble_o = sn_q;
  assign channel_o       = ch_q;
  assign first_data_o    = d1_q;
  assign second_data_o   = d2_q;
  assign raw_value_o     = raw_q;
  assign last_o          = last_q;

  `MSP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(SYSEX_DEPTH))
  `MSP_ASSERT_NOW(a_idx_in_range, seq_q != msp_pkg::ST_ACCEPT, CW'(idx_q) < cnt_q)
  `MSP_ASSERT_NEXT(a_end_starts_dump, sx_end_acc, seq_q == msp_pkg::ST_READ)
  `MSP_ASSERT_NEXT(a_last_ends_dump, load && dump_last,
                   seq_q == msp_pkg::ST_ACCEPT && out_valid_q && last_q)

endmodule
